@@ sv/irb_pkg.sv @@
// ---------------------------------------------------------------------------
// irb_pkg: shared types and constants of the rotation engine
// Configuration register set, item classification and sizing defaults.
// ---------------------------------------------------------------------------
package irb_pkg;

    // Default sizes for the top level parameters.
    localparam int MAX_WIDTH_DEF  = 512;
    localparam int MAX_HEIGHT_DEF = 512;
    localparam int PIXEL_BITS_DEF = 16;

    // Fixed field widths.
    localparam int COORD_W   = 10;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // Queue depths on both sides of the engine.
    localparam int IN_DEPTH  = 4;
    localparam int OUT_DEPTH = 16;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COS        = 3'd0,
        CFG_SIN        = 3'd1,
        CFG_SRC_WIDTH  = 3'd2,
        CFG_SRC_HEIGHT = 3'd3,
        CFG_CENTER_COL = 3'd4,
        CFG_CENTER_ROW = 3'd5,
        CFG_HALF_DW    = 3'd6,
        CFG_HALF_DH    = 3'd7
    } t_cfg_idx;

    // Configuration register contents.
    typedef struct packed {
        logic signed [15:0] cos_angle;
        logic signed [15:0] sin_angle;
        logic [9:0]         src_width;
        logic [9:0]         src_height;
        logic [9:0]         center_col;
        logic [9:0]         center_row;
        logic [8:0]         half_dest_width;
        logic [8:0]         half_dest_height;
    } t_cfg;

    // Classification of a queued item.
    typedef struct packed {
        logic req;   // request for a rotated pixel
        logic wr;    // pixel write that lands inside the store
    } t_cls;

endpackage

@@ sv/irb_fifo.sv @@
// ---------------------------------------------------------------------------
// irb_fifo: small register queue
// First-in first-out buffer with occupancy count, used on both sides.
// ---------------------------------------------------------------------------
module irb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_full,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (rd_en) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + CW'(1);
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

@@ sv/irb_front.sv @@
// ---------------------------------------------------------------------------
// irb_front: input side of the rotation engine
// Accepts items, classifies them as requests or in-range writes, and
// queues them for the back end.
// ---------------------------------------------------------------------------
module irb_front #(
    parameter int MAX_WIDTH  = irb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = irb_pkg::MAX_HEIGHT_DEF,
    parameter int PIXEL_BITS = irb_pkg::PIXEL_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    output logic                        o_full,
    input  logic                        i_command,
    input  logic [irb_pkg::COORD_W-1:0] i_column,
    input  logic [irb_pkg::COORD_W-1:0] i_row,
    input  logic [PIXEL_BITS-1:0]       i_sample,
    input  logic                        i_pop,
    output logic                        o_valid,
    output irb_pkg::t_cls               o_cls,
    output logic [irb_pkg::COORD_W-1:0] o_column,
    output logic [irb_pkg::COORD_W-1:0] o_row,
    output logic [PIXEL_BITS-1:0]       o_sample
);
    localparam int CW = irb_pkg::COORD_W;
    localparam int QW = 2 + 2 * CW + PIXEL_BITS;

    irb_pkg::t_cls in_cls;
    logic [QW-1:0] q_out;
    logic          empty;

    // Classify on entry: writes outside the store are marked here and never written.
    always_comb begin
        in_cls.req = i_command;
        in_cls.wr  = !i_command
                     && (32'(i_column) < MAX_WIDTH)
                     && (32'(i_row) < MAX_HEIGHT);
    end

    irb_fifo #(
        .WIDTH (QW),
        .DEPTH (irb_pkg::IN_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  ({in_cls, i_column, i_row, i_sample}),
        .i_pop   (i_pop),
        .o_data  (q_out),
        .o_full  (o_full),
        .o_empty (empty),
        .o_count ()
    );

    assign o_valid = !empty;
    assign {o_cls, o_column, o_row, o_sample} = q_out;

endmodule

@@ sv/irb_back.sv @@
// ---------------------------------------------------------------------------
// irb_back: execution side of the rotation engine
// Coordinate mapping, edge clamp, four-bank frame store and bilinear blend:
// eight-stage pipeline, one item per cycle while the result queue has room.
// ---------------------------------------------------------------------------
module irb_back #(
    parameter int MAX_WIDTH  = irb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = irb_pkg::MAX_HEIGHT_DEF,
    parameter int PIXEL_BITS = irb_pkg::PIXEL_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  irb_pkg::t_cfg               i_cfg,
    input  logic                        i_valid,
    input  irb_pkg::t_cls               i_cls,
    input  logic [irb_pkg::COORD_W-1:0] i_column,
    input  logic [irb_pkg::COORD_W-1:0] i_row,
    input  logic [PIXEL_BITS-1:0]       i_sample,
    output logic                        o_pop,
    input  logic [$clog2(irb_pkg::OUT_DEPTH+1)-1:0] i_out_count,
    output logic                        o_res_valid,
    output logic [PIXEL_BITS-1:0]       o_res_value,
    output logic [irb_pkg::COORD_W-1:0] o_res_col,
    output logic [irb_pkg::COORD_W-1:0] o_res_row
);
    localparam int P   = PIXEL_BITS;
    localparam int CW  = irb_pkg::COORD_W;
    localparam int BC  = (MAX_WIDTH + 1) / 2;
    localparam int BR  = (MAX_HEIGHT + 1) / 2;
    localparam int BD  = BC * BR;
    localparam int AW  = (BD > 1) ? $clog2(BD) : 1;
    localparam int PW6 = P + 10;
    localparam int PW7 = P + 11;
    localparam int PW8 = P + 21;
    localparam int PW9 = P + 22;

    // Stage 1: offsets from the destination center.
    logic                 r1_req, r1_wr;
    logic [CW-1:0]        r1_col, r1_row;
    logic [P-1:0]         r1_sample;
    logic signed [11:0]   r1_dc, r1_dr;
    // Stage 2: rotation products.
    logic                 r2_req, r2_wr;
    logic [CW-1:0]        r2_col, r2_row;
    logic [P-1:0]         r2_sample;
    logic signed [27:0]   r2_pcc, r2_prs, r2_prc, r2_pcs;
    // Stage 3: source coordinate, 8 fraction bits.
    logic                 r3_req, r3_wr;
    logic [CW-1:0]        r3_col, r3_row;
    logic [P-1:0]         r3_sample;
    logic signed [23:0]   r3_xs, r3_ys;
    // Stage 4: clamped coordinate split into integer and fraction.
    logic                 r4_req, r4_wr;
    logic [CW-1:0]        r4_col, r4_row;
    logic [P-1:0]         r4_sample;
    logic [9:0]           r4_ix, r4_iy;
    logic [7:0]           r4_fx, r4_fy;
    // Stage 5: frame store read.
    logic                 r5_req;
    logic [CW-1:0]        r5_col, r5_row;
    logic [7:0]           r5_fx, r5_fy;
    logic                 r5_ix0, r5_iy0;
    // Stage 6: horizontal weighting.
    logic                 r6_req;
    logic [CW-1:0]        r6_col, r6_row;
    logic [7:0]           r6_fy;
    logic signed [PW6-1:0] r6_a, r6_b, r6_c, r6_d;
    // Stage 7: row sums.
    logic                 r7_req;
    logic [CW-1:0]        r7_col, r7_row;
    logic [7:0]           r7_fy;
    logic signed [PW7-1:0] r7_top, r7_bot;
    // Stage 8: vertical weighting.
    logic                 r8_req;
    logic [CW-1:0]        r8_col, r8_row;
    logic signed [PW8-1:0] r8_t, r8_b;

    // Issue: take an item only when the result queue has room for every
    // request already in flight plus this one.
    int inflight;
    assign inflight = $countones({r1_req, r2_req, r3_req, r4_req,
                                  r5_req, r6_req, r7_req, r8_req});
    assign o_pop = i_valid && ((int'(i_out_count) + inflight) < irb_pkg::OUT_DEPTH);

    // Control flags of the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_req <= 1'b0; r1_wr <= 1'b0;
            r2_req <= 1'b0; r2_wr <= 1'b0;
            r3_req <= 1'b0; r3_wr <= 1'b0;
            r4_req <= 1'b0; r4_wr <= 1'b0;
            r5_req <= 1'b0; r6_req <= 1'b0;
            r7_req <= 1'b0; r8_req <= 1'b0;
        end else begin
            r1_req <= o_pop && i_cls.req;
            r1_wr  <= o_pop && i_cls.wr;
            r2_req <= r1_req; r2_wr <= r1_wr;
            r3_req <= r2_req; r3_wr <= r2_wr;
            r4_req <= r3_req; r4_wr <= r3_wr;
            r5_req <= r4_req; r6_req <= r5_req;
            r7_req <= r6_req; r8_req <= r7_req;
        end
    end

    // Stages 1 and 2: offsets and the four rotation products.
    always_ff @(posedge i_clk) begin
        r1_col    <= i_column;
        r1_row    <= i_row;
        r1_sample <= i_sample;
        r1_dc     <= $signed({2'b00, i_column}) - $signed({3'b000, i_cfg.half_dest_width});
        r1_dr     <= $signed({2'b00, i_row}) - $signed({3'b000, i_cfg.half_dest_height});

        r2_col    <= r1_col;
        r2_row    <= r1_row;
        r2_sample <= r1_sample;
        r2_pcc    <= 28'(r1_dc) * 28'(i_cfg.cos_angle);
        r2_prs    <= 28'(r1_dr) * 28'(i_cfg.sin_angle);
        r2_prc    <= 28'(r1_dr) * 28'(i_cfg.cos_angle);
        r2_pcs    <= 28'(r1_dc) * 28'(i_cfg.sin_angle);
    end

    // Stage 3: round to 8 fraction bits and add the source center.
    logic signed [28:0] sum_x, sum_y;
    logic signed [23:0] ctr_x, ctr_y;
    always_comb begin
        sum_x = 29'(r2_pcc) + 29'(r2_prs) + 29'sd32;
        sum_y = 29'(r2_prc) - 29'(r2_pcs) + 29'sd32;
        ctr_x = $signed({6'b0, i_cfg.center_col, 8'b0});
        ctr_y = $signed({6'b0, i_cfg.center_row, 8'b0});
    end

    always_ff @(posedge i_clk) begin
        r3_col    <= r2_col;
        r3_row    <= r2_row;
        r3_sample <= r2_sample;
        r3_xs     <= 24'(sum_x >>> 6) + ctr_x;
        r3_ys     <= 24'(sum_y >>> 6) + ctr_y;
    end

    // Stage 4: clamp to the image edges. The column stops one pixel
    // earlier than the row does.
    int                 w_sat, h_sat;
    logic signed [23:0] lim_x, lim_y_hi, lim_y, xc, yc;
    always_comb begin
        w_sat = int'(i_cfg.src_width);
        if (w_sat < 2) begin
            w_sat = 2;
        end else if (w_sat > MAX_WIDTH) begin
            w_sat = MAX_WIDTH;
        end
        h_sat = int'(i_cfg.src_height);
        if (h_sat < 2) begin
            h_sat = 2;
        end else if (h_sat > MAX_HEIGHT) begin
            h_sat = MAX_HEIGHT;
        end
        lim_x    = 24'((w_sat - 2) * 256);
        lim_y_hi = 24'((h_sat - 1) * 256);
        lim_y    = 24'((h_sat - 2) * 256);
        if (r3_xs >= lim_x) begin
            xc = lim_x;
        end else if (r3_xs < 0) begin
            xc = '0;
        end else begin
            xc = r3_xs;
        end
        if (r3_ys >= lim_y_hi) begin
            yc = lim_y;
        end else if (r3_ys < 0) begin
            yc = '0;
        end else begin
            yc = r3_ys;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_col    <= r3_col;
        r4_row    <= r3_row;
        r4_sample <= r3_sample;
        r4_ix     <= xc[17:8];
        r4_fx     <= xc[7:0];
        r4_iy     <= yc[17:8];
        r4_fy     <= yc[7:0];
    end

    // Stage 5: four banks split by column and row parity, so the four
    // neighbors always fall into different banks.
    logic signed [P-1:0] bank_q [4];

    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam bit BX = (b % 2) == 1;
        localparam bit BY = (b / 2) == 1;

        logic signed [P-1:0] r_mem [BD];
        logic signed [P-1:0] r_q;
        logic [9:0]          csel, rsel;
        logic [AW-1:0]       rd_addr, wr_addr;
        logic                wr_en;

        always_comb begin
            csel    = (r4_ix[0] == BX) ? r4_ix : r4_ix + 10'd1;
            rsel    = (r4_iy[0] == BY) ? r4_iy : r4_iy + 10'd1;
            rd_addr = AW'(int'(rsel[9:1]) * BC + int'(csel[9:1]));
            wr_addr = AW'(int'(r4_row[CW-1:1]) * BC + int'(r4_col[CW-1:1]));
            wr_en   = r4_wr && (r4_col[0] == BX) && (r4_row[0] == BY);
        end

        always_ff @(posedge i_clk) begin
            if (wr_en) begin
                r_mem[wr_addr] <= r4_sample;
            end
            r_q <= r_mem[rd_addr];
        end

        assign bank_q[b] = r_q;
    end

    always_ff @(posedge i_clk) begin
        r5_col <= r4_col;
        r5_row <= r4_row;
        r5_fx  <= r4_fx;
        r5_fy  <= r4_fy;
        r5_ix0 <= r4_ix[0];
        r5_iy0 <= r4_iy[0];
    end

    // Stage 6: route bank data to neighbor positions and weight by column.
    logic signed [P-1:0] p00, p10, p01, p11;
    logic signed [9:0]   wx0, wx1;
    always_comb begin
        p00 = bank_q[{r5_iy0, r5_ix0}];
        p10 = bank_q[{r5_iy0, !r5_ix0}];
        p01 = bank_q[{!r5_iy0, r5_ix0}];
        p11 = bank_q[{!r5_iy0, !r5_ix0}];
        wx1 = $signed({2'b00, r5_fx});
        wx0 = 10'sd256 - wx1;
    end

    always_ff @(posedge i_clk) begin
        r6_col <= r5_col;
        r6_row <= r5_row;
        r6_fy  <= r5_fy;
        r6_a   <= PW6'(p00) * PW6'(wx0);
        r6_b   <= PW6'(p10) * PW6'(wx1);
        r6_c   <= PW6'(p01) * PW6'(wx0);
        r6_d   <= PW6'(p11) * PW6'(wx1);
    end

    // Stage 7: row sums.
    always_ff @(posedge i_clk) begin
        r7_col <= r6_col;
        r7_row <= r6_row;
        r7_fy  <= r6_fy;
        r7_top <= PW7'(r6_a) + PW7'(r6_b);
        r7_bot <= PW7'(r6_c) + PW7'(r6_d);
    end

    // Stage 8: weight by row.
    logic signed [9:0] wy0, wy1;
    assign wy1 = $signed({2'b00, r7_fy});
    assign wy0 = 10'sd256 - wy1;

    always_ff @(posedge i_clk) begin
        r8_col <= r7_col;
        r8_row <= r7_row;
        r8_t   <= PW8'(r7_top) * PW8'(wy0);
        r8_b   <= PW8'(r7_bot) * PW8'(wy1);
    end

    // Final sum with rounding; the result queue registers it.
    logic signed [PW9-1:0] blend;
    assign blend       = (PW9'(r8_t) + PW9'(r8_b) + PW9'(32768)) >>> 16;
    assign o_res_valid = r8_req;
    assign o_res_value = blend[P-1:0];
    assign o_res_col   = r8_col;
    assign o_res_row   = r8_row;

endmodule

@@ sv/image_rotate_bilinear.sv @@
// ---------------------------------------------------------------------------
// image_rotate_bilinear: rotated-pixel engine with bilinear interpolation
// Frame store writes and rotated-pixel requests in one ordered stream.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (push/full): command 0 writes sample at (column, row) of
//   the frame store, command 1 requests the destination pixel (column, row).
//   Writes give no result; each request gives one result, in order.
//   Result channel (empty/pop): the oldest result waits on the o_ ports
//   while empty is low and leaves with each pop transfer.
//   Configuration channel (valid/ready) is always ready; users must change
//   registers only while the engine is idle, the block does not enforce it.
//   A request passes through the input queue, the eight pipeline stages and
//   the write into the result queue before it reaches the result ports.
//   Throughput: one item per cycle while the result queue has room, set by
//   the four-bank frame store, which serves all four neighbors of a request
//   with one read each.
//   Stalls: when pop stays low, the result queue fills and the engine stops
//   issuing items so no result is lost; full rises once the input queue fills.
//   Reset empties both queues and loads the register defaults; the frame
//   store keeps no defined contents until written.
// ---------------------------------------------------------------------------
module image_rotate_bilinear #(
    parameter int MAX_WIDTH  = irb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = irb_pkg::MAX_HEIGHT_DEF,
    parameter int PIXEL_BITS = irb_pkg::PIXEL_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          i_command,
    input  logic [irb_pkg::COORD_W-1:0]   i_column,
    input  logic [irb_pkg::COORD_W-1:0]   i_row,
    input  logic [PIXEL_BITS-1:0]         i_sample,
    output logic                          empty,
    input  logic                          pop,
    output logic [PIXEL_BITS-1:0]         o_pixel_value,
    output logic [irb_pkg::COORD_W-1:0]   o_dest_column,
    output logic [irb_pkg::COORD_W-1:0]   o_dest_row,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [irb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [irb_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    localparam int CW = irb_pkg::COORD_W;
    localparam int RW = PIXEL_BITS + 2 * CW;

    irb_pkg::t_cfg r_cfg;
    irb_pkg::t_cls q_cls;
    logic                  q_valid, q_pop;
    logic [CW-1:0]         q_col, q_row;
    logic [PIXEL_BITS-1:0] q_sample;
    logic                  res_valid;
    logic [PIXEL_BITS-1:0] res_value;
    logic [CW-1:0]         res_col, res_row;
    logic [$clog2(irb_pkg::OUT_DEPTH+1)-1:0] out_count;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cos_angle        <= 16'sd16384;
            r_cfg.sin_angle        <= 16'sd0;
            r_cfg.src_width        <= 10'd512;
            r_cfg.src_height       <= 10'd512;
            r_cfg.center_col       <= 10'd256;
            r_cfg.center_row       <= 10'd256;
            r_cfg.half_dest_width  <= 9'd256;
            r_cfg.half_dest_height <= 9'd256;
        end else if (i_cfg_valid) begin
            case (irb_pkg::t_cfg_idx'(i_cfg_index))
                irb_pkg::CFG_COS:        r_cfg.cos_angle        <= $signed(i_cfg_data);
                irb_pkg::CFG_SIN:        r_cfg.sin_angle        <= $signed(i_cfg_data);
                irb_pkg::CFG_SRC_WIDTH:  r_cfg.src_width        <= i_cfg_data[9:0];
                irb_pkg::CFG_SRC_HEIGHT: r_cfg.src_height       <= i_cfg_data[9:0];
                irb_pkg::CFG_CENTER_COL: r_cfg.center_col       <= i_cfg_data[9:0];
                irb_pkg::CFG_CENTER_ROW: r_cfg.center_row       <= i_cfg_data[9:0];
                irb_pkg::CFG_HALF_DW:    r_cfg.half_dest_width  <= i_cfg_data[8:0];
                irb_pkg::CFG_HALF_DH:    r_cfg.half_dest_height <= i_cfg_data[8:0];
                default: begin
                end
            endcase
        end
    end

    // Front end: input queue and classification.
    irb_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_full    (full),
        .i_command (i_command),
        .i_column  (i_column),
        .i_row     (i_row),
        .i_sample  (i_sample),
        .i_pop     (q_pop),
        .o_valid   (q_valid),
        .o_cls     (q_cls),
        .o_column  (q_col),
        .o_row     (q_row),
        .o_sample  (q_sample)
    );

    // Back end: mapping, frame store and interpolation.
    irb_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (q_valid),
        .i_cls       (q_cls),
        .i_column    (q_col),
        .i_row       (q_row),
        .i_sample    (q_sample),
        .o_pop       (q_pop),
        .i_out_count (out_count),
        .o_res_valid (res_valid),
        .o_res_value (res_value),
        .o_res_col   (res_col),
        .o_res_row   (res_row)
    );

    // Result queue.
    logic [RW-1:0] res_q;

    irb_fifo #(
        .WIDTH (RW),
        .DEPTH (irb_pkg::OUT_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  ({res_value, res_col, res_row}),
        .i_pop   (pop),
        .o_data  (res_q),
        .o_full  (),
        .o_empty (empty),
        .o_count (out_count)
    );

    assign {o_pixel_value, o_dest_column, o_dest_row} = res_q;

endmodule

@@ sv/irb_check.sv @@
// ---------------------------------------------------------------------------
// irb_check: port-level checks for the rotation engine
// Reset behavior, result holding and minimum result latency.
// ---------------------------------------------------------------------------
module irb_check #(
    parameter int PIXEL_BITS = irb_pkg::PIXEL_BITS_DEF
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        full,
    input logic                        empty,
    input logic                        pop,
    input logic [PIXEL_BITS-1:0]       o_pixel_value,
    input logic [irb_pkg::COORD_W-1:0] o_dest_column,
    input logic [irb_pkg::COORD_W-1:0] o_dest_row
);
    // Reset leaves both queues empty.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not cleared by reset");

    // A waiting result holds until it is taken.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_pixel_value)
                              && $stable(o_dest_column) && $stable(o_dest_row)))
        else $error("waiting result changed before transfer");

    // No result can appear in the first cycles after reset.
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(!i_rst_n) ##1 1'b1) |-> empty)
        else $error("result appeared too soon after reset");

endmodule

bind image_rotate_bilinear irb_check #(
    .PIXEL_BITS (PIXEL_BITS)
) u_irb_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .o_pixel_value (o_pixel_value),
    .o_dest_column (o_dest_column),
    .o_dest_row    (o_dest_row)
);

@@ tb/sv/irb_scoreboard.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// irb_scoreboard: result checker for the rotation engine
// Watches the input, result and configuration channels. It keeps its own
// copy of the frame store and registers, predicts each rotated pixel and
// compares every result transfer with the oldest prediction.
// ---------------------------------------------------------------------------
module irb_scoreboard (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    input  logic                          full,
    input  logic                          i_command,
    input  logic [irb_pkg::COORD_W-1:0]   i_column,
    input  logic [irb_pkg::COORD_W-1:0]   i_row,
    input  logic [15:0]                   i_sample,
    input  logic                          empty,
    input  logic                          pop,
    input  logic [15:0]                   i_pixel_value,
    input  logic [irb_pkg::COORD_W-1:0]   i_dest_column,
    input  logic [irb_pkg::COORD_W-1:0]   i_dest_row,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [irb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [irb_pkg::CFG_DAT_W-1:0] i_cfg_data,
    output int                            o_pending,
    output int                            o_errors
);
    localparam int MW = irb_pkg::MAX_WIDTH_DEF;
    localparam int MH = irb_pkg::MAX_HEIGHT_DEF;

    typedef struct {
        logic [15:0]                 pixel;
        logic [irb_pkg::COORD_W-1:0] col;
        logic [irb_pkg::COORD_W-1:0] row;
    } t_rotated_px;

    logic [15:0]    frame_copy [0:MW*MH-1];
    irb_pkg::t_cfg  regs;
    t_rotated_px    rotated_q[$];

    // Source pixel from the shadow store, zero outside it.
    function automatic longint src_px(longint x, longint y);
        if (x < 0 || x >= MW || y < 0 || y >= MH) begin
            return 0;
        end
        return longint'($signed(frame_copy[y * MW + x]));
    endfunction

    // Rotated, clamped and bilinearly blended source value.
    function automatic logic [15:0] rotate_px(logic [irb_pkg::COORD_W-1:0] col,
                                              logic [irb_pkg::COORD_W-1:0] row);
        longint c, s, dc, dr, xs, ys, w, h, ix, iy, fx, fy, top, bot, v;
        c  = longint'(regs.cos_angle);
        s  = longint'(regs.sin_angle);
        dc = longint'(col) - longint'(regs.half_dest_width);
        dr = longint'(row) - longint'(regs.half_dest_height);
        xs = longint'(regs.center_col) * 256 + ((dc * c + dr * s + 32) >>> 6);
        ys = longint'(regs.center_row) * 256 + ((dr * c - dc * s + 32) >>> 6);
        w  = longint'(regs.src_width);
        h  = longint'(regs.src_height);
        if (w < 2) w = 2;
        if (w > MW) w = MW;
        if (h < 2) h = 2;
        if (h > MH) h = MH;
        // The column limit sits one pixel further in than the row limit.
        if (xs + 256 >= (w - 1) * 256) xs = (w - 2) * 256;
        if (xs < 0) xs = 0;
        if (ys + 256 >= h * 256) ys = (h - 2) * 256;
        if (ys < 0) ys = 0;
        ix  = xs >>> 8;
        fx  = xs & 255;
        iy  = ys >>> 8;
        fy  = ys & 255;
        top = src_px(ix, iy) * (256 - fx) + src_px(ix + 1, iy) * fx;
        bot = src_px(ix, iy + 1) * (256 - fx) + src_px(ix + 1, iy + 1) * fx;
        v   = (top * (256 - fy) + bot * fy + 32768) >>> 16;
        return v[15:0];
    endfunction

    // Track every transfer on the three channels.
    always @(posedge i_clk) begin
        t_rotated_px want;
        int          errs;
        errs = 0;
        if (!i_rst_n) begin
            regs <= '{cos_angle: 16'sd16384, sin_angle: 16'sd0,
                      src_width: 10'd512, src_height: 10'd512,
                      center_col: 10'd256, center_row: 10'd256,
                      half_dest_width: 9'd256, half_dest_height: 9'd256};
            rotated_q.delete();
            o_errors  <= 0;
            o_pending <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (irb_pkg::t_cfg_idx'(i_cfg_index))
                    irb_pkg::CFG_COS:        regs.cos_angle        <= i_cfg_data;
                    irb_pkg::CFG_SIN:        regs.sin_angle        <= i_cfg_data;
                    irb_pkg::CFG_SRC_WIDTH:  regs.src_width        <= i_cfg_data[9:0];
                    irb_pkg::CFG_SRC_HEIGHT: regs.src_height       <= i_cfg_data[9:0];
                    irb_pkg::CFG_CENTER_COL: regs.center_col       <= i_cfg_data[9:0];
                    irb_pkg::CFG_CENTER_ROW: regs.center_row       <= i_cfg_data[9:0];
                    irb_pkg::CFG_HALF_DW:    regs.half_dest_width  <= i_cfg_data[8:0];
                    irb_pkg::CFG_HALF_DH:    regs.half_dest_height <= i_cfg_data[8:0];
                    default: ;
                endcase
            end
            if (push && !full) begin
                if (i_command) begin
                    want.pixel = rotate_px(i_column, i_row);
                    want.col   = i_column;
                    want.row   = i_row;
                    rotated_q.push_back(want);
                end else if (i_column < MW && i_row < MH) begin
                    frame_copy[i_row * MW + i_column] = i_sample;
                end
            end
            if (pop && !empty) begin
                if (rotated_q.size() == 0) begin
                    $error("unexpected result: pixel_value %0d", $signed(i_pixel_value));
                    errs++;
                end else begin
                    want = rotated_q.pop_front();
                    if (want.pixel !== i_pixel_value) begin
                        $error("pixel_value: expected %0d, actual %0d",
                               $signed(want.pixel), $signed(i_pixel_value));
                        errs++;
                    end
                    if (want.col !== i_dest_column) begin
                        $error("dest_column: expected %0d, actual %0d",
                               want.col, i_dest_column);
                        errs++;
                    end
                    if (want.row !== i_dest_row) begin
                        $error("dest_row: expected %0d, actual %0d", want.row, i_dest_row);
                        errs++;
                    end
                end
            end
            o_errors  <= o_errors + errs;
            o_pending <= rotated_q.size();
        end
    end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: stimulus and verdict for the rotation engine
// Fills the used source area, then sends directed and random writes and
// rotated-pixel requests over several settings; both sides idle at random.
// ---------------------------------------------------------------------------
module testbench;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 40;
    localparam int MW          = irb_pkg::MAX_WIDTH_DEF;
    localparam int MH          = irb_pkg::MAX_HEIGHT_DEF;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          push;
    logic                          full;
    logic                          i_command;
    logic [irb_pkg::COORD_W-1:0]   i_column;
    logic [irb_pkg::COORD_W-1:0]   i_row;
    logic [15:0]                   i_sample;
    logic                          empty;
    logic                          pop;
    logic [15:0]                   o_pixel_value;
    logic [irb_pkg::COORD_W-1:0]   o_dest_column;
    logic [irb_pkg::COORD_W-1:0]   o_dest_row;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [irb_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [irb_pkg::CFG_DAT_W-1:0] i_cfg_data;
    int                            pending;
    int                            errors;
    int                            cycles;
    bit                            calm;
    bit                            stall_req;
    bit                            written [0:MH-1][0:MW-1];
    int                            eff_w, eff_h;
    int                            hdw, hdh;

    image_rotate_bilinear u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_command     (i_command),
        .i_column      (i_column),
        .i_row         (i_row),
        .i_sample      (i_sample),
        .empty         (empty),
        .pop           (pop),
        .o_pixel_value (o_pixel_value),
        .o_dest_column (o_dest_column),
        .o_dest_row    (o_dest_row),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    irb_scoreboard u_scoreboard (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_command     (i_command),
        .i_column      (i_column),
        .i_row         (i_row),
        .i_sample      (i_sample),
        .empty         (empty),
        .pop           (pop),
        .i_pixel_value (o_pixel_value),
        .i_dest_column (o_dest_column),
        .i_dest_row    (o_dest_row),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_pending     (pending),
        .o_errors      (errors)
    );

    // Clock.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Cycle budget.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[image_rotate_bilinear] ERROR");
            $finish;
        end
    end

    // Result side: random pop gaps, one long hold-off on request.
    initial begin
        bit held;
        held = 1'b0;
        pop  = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (stall_req && !held) begin
                held = 1'b1;
                pop <= 1'b0;
                repeat (400) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // One item transfer; push stays high afterwards unless a gap follows.
    task automatic put_item(logic cmd, int col, int row, logic [15:0] smp);
        if (!calm && $urandom_range(0, 7) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        push      <= 1'b1;
        i_command <= cmd;
        i_column  <= col[irb_pkg::COORD_W-1:0];
        i_row     <= row[irb_pkg::COORD_W-1:0];
        i_sample  <= smp;
        do @(posedge i_clk); while (full);
        if (!cmd && col < MW && row < MH) begin
            written[row][col] = 1'b1;
        end
    endtask

    // Wait until every result has left and the pipeline is quiet.
    task automatic settle();
        push <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // One register write transfer; valid is lowered by the caller.
    task automatic reg_write(irb_pkg::t_cfg_idx idx, int value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[15:0];
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Load a full register set and write every source pixel it can read.
    task automatic load_setting(int c, int s, int w, int h, int cc, int cr,
                                int hw, int hh);
        reg_write(irb_pkg::CFG_COS, c);
        reg_write(irb_pkg::CFG_SIN, s);
        reg_write(irb_pkg::CFG_SRC_WIDTH, w);
        reg_write(irb_pkg::CFG_SRC_HEIGHT, h);
        reg_write(irb_pkg::CFG_CENTER_COL, cc);
        reg_write(irb_pkg::CFG_CENTER_ROW, cr);
        reg_write(irb_pkg::CFG_HALF_DW, hw);
        reg_write(irb_pkg::CFG_HALF_DH, hh);
        i_cfg_valid <= 1'b0;
        eff_w = (w < 2) ? 2 : (w > MW) ? MW : w;
        eff_h = (h < 2) ? 2 : (h > MH) ? MH : h;
        hdw   = hw;
        hdh   = hh;
        for (int y = 0; y < eff_h; y++) begin
            for (int x = 0; x < eff_w; x++) begin
                if (!written[y][x]) begin
                    put_item(1'b0, x, y, 16'($urandom));
                end
            end
        end
    endtask

    // Random item: mostly requests; half land near the destination center.
    task automatic random_item();
        int pick, col, row;
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
            if ($urandom_range(0, 3) == 0) begin
                put_item(1'b0, $urandom_range(0, 1023), $urandom_range(0, 1023),
                         16'($urandom));
            end else begin
                put_item(1'b0, $urandom_range(0, eff_w - 1), $urandom_range(0, eff_h - 1),
                         16'($urandom));
            end
        end else begin
            if (pick < 5) begin
                col = $urandom_range(0, 1023);
                row = $urandom_range(0, 1023);
            end else begin
                col = (hdw + $urandom_range(0, 2 * eff_w) - eff_w) & 1023;
                row = (hdh + $urandom_range(0, 2 * eff_h) - eff_h) & 1023;
            end
            put_item(1'b1, col, row, 16'($urandom));
        end
    endtask

    // Stimulus.
    initial begin
        int c, s, w, h;
        cycles      = 0;
        calm        = 1'b0;
        stall_req   = 1'b0;
        i_rst_n     = 1'b0;
        push        = 1'b0;
        i_command   = 1'b0;
        i_column    = '0;
        i_row       = '0;
        i_sample    = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = irb_pkg::CFG_COS;
        i_cfg_data  = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: a 4 x 4 source with extreme samples, corner requests.
        load_setting(16384, 0, 4, 4, 1, 1, 2, 2);
        put_item(1'b0, 0, 0, 16'h8000);
        put_item(1'b0, 1, 1, 16'h7fff);
        put_item(1'b0, 1023, 1023, 16'h1234);
        put_item(1'b0, 600, 3, 16'h5555);
        put_item(1'b0, 3, 512, 16'haaaa);
        put_item(1'b1, 0, 0, 16'hffff);
        put_item(1'b1, 1023, 1023, 16'h0000);
        put_item(1'b1, 2, 2, 16'h0000);
        put_item(1'b1, 3, 3, 16'h0000);
        put_item(1'b1, 1023, 0, 16'h0000);
        put_item(1'b1, 0, 1023, 16'h0000);
        put_item(1'b1, 682, 341, 16'h0000);
        put_item(1'b1, 341, 682, 16'h0000);
        settle();

        // Random phases over several settings; the first ones are extremes.
        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: load_setting(-16384, 0, 1023, 2, 1023, 0, 511, 0);
                1: load_setting(0, 16384, 2, 3, 0, 1023, 0, 511);
                2: load_setting(0, -16384, 0, 5, 1, 300, 100, 200);
                3: load_setting(32767, -32768, 1, 6, 5, 5, 255, 256);
                default: begin
                    if ($urandom_range(0, 1)) begin
                        c = $urandom_range(0, 32768) - 16384;
                        s = $urandom_range(0, 32768) - 16384;
                    end else begin
                        c = $urandom_range(0, 65535);
                        s = $urandom_range(0, 65535);
                    end
                    w = $urandom_range(2, 16);
                    h = $urandom_range(2, 16);
                    load_setting(c, s, w, h, $urandom_range(0, w), $urandom_range(0, h),
                                 $urandom_range(0, 511), $urandom_range(0, 511));
                end
            endcase
            if (ph == 5) stall_req = 1'b1;
            if (ph == 9) calm = 1'b1;
            for (int n = 0; n < 50; n++) begin
                random_item();
            end
            settle();
        end

        if (errors == 0) begin
            $display("[image_rotate_bilinear] OK");
        end else begin
            $display("[image_rotate_bilinear] ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/irb_pkg.sv
sv/irb_fifo.sv
sv/irb_front.sv
sv/irb_back.sv
sv/image_rotate_bilinear.sv
sv/irb_check.sv
tb/sv/irb_scoreboard.sv
tb/sv/testbench.sv
